FILE: src/gtgw_pkg.sv
package gtgw_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] PAGE_CMD    = 8'hB8;
	localparam logic [7:0] COLUMN_CMD  = 8'h40;
	localparam logic [6:0] GLYPH_BASE  = 7'h20;
	localparam logic [6:0] GLYPH_NONE  = 7'h7F;
	localparam logic [7:0] BLANK_BYTE  = 8'h00;
	localparam logic [4:0] HALF_SPLIT  = 5'd10;
	localparam logic [7:0] CELL_WIDTH  = 8'd6;
	localparam logic [7:0] LEFT_OFFSET = 8'd4;
	localparam logic [2:0] GLYPH_COLS  = 3'd5;

	localparam logic       REQ_POSITION = 1'b0;
	localparam logic       REQ_CHAR     = 1'b1;

	localparam logic       WR_CMD  = 1'b0;
	localparam logic       WR_DATA = 1'b1;

	localparam logic [1:0] PANEL_LEFT  = 2'd0;
	localparam logic [1:0] PANEL_RIGHT = 2'd1;
	localparam logic [1:0] PANEL_BOTH  = 2'd2;

	typedef struct packed {
		logic        is_char;
		logic        lead_reset;
		logic        half;
		logic [7:0]  page_cmd;
		logic [7:0]  col_cmd;
		logic        col_half;
		logic [39:0] glyph;
	} op_t;

	localparam logic [39:0] FONT_ROM [95] = '{
		40'h0000000000, 40'h00004f0000, 40'h0007000700,
		40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
		40'h3649552250, 40'h0005030000, 40'h001c224100,
		40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
		40'h4261514946, 40'h2141454b31, 40'h1814127f10,
		40'h2745454539, 40'h3c4a494930, 40'h0171090503,
		40'h3649494936, 40'h064949291e, 40'h0036360000,
		40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413e,
		40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
		40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
		40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
		40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
		40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
		40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
		40'h2649494932, 40'h01017f0101, 40'h3f4040403f,
		40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
		40'h0708700807, 40'h6151494543, 40'h007f414100,
		40'h0204081020, 40'h0041417f00, 40'h0402010204,
		40'h4040404040, 40'h0001020400, 40'h2054545478,
		40'h7f48444438, 40'h3844444420, 40'h384444487f,
		40'h3854545418, 40'h087e090102, 40'h0c5252523e,
		40'h7f08040478, 40'h00047d0000, 40'h2040443d00,
		40'h7f10284400, 40'h00417f4000, 40'h7c0418047c,
		40'h7c08040478, 40'h3844444438, 40'h7c14141408,
		40'h081414187c, 40'h7c08040408, 40'h4854545420,
		40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
		40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
		40'h4464544c44, 40'h0008364100, 40'h0000770000,
		40'h0041360800, 40'h0804081008
	};

endpackage

FILE: src/gtgw_front.sv
module gtgw_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             req_type,
	input  logic [2:0]       text_page,
	input  logic [4:0]       text_column,
	input  logic [6:0]       char_code,
	output logic             push,
	output gtgw_pkg::op_t    push_op,
	input  logic             q_full
);

	logic [7:0] cursor_q;
	logic       left;
	logic [4:0] col_off;
	logic [7:0] col_mul;
	logic       has_glyph;
	logic [6:0] glyph_idx;

	assign req_ready = !q_full;
	assign push      = req_valid && req_ready;

	always_comb begin
		left      = text_column < gtgw_pkg::HALF_SPLIT;
		col_off   = left ? text_column : text_column - gtgw_pkg::HALF_SPLIT;
		col_mul   = 8'({3'b000, col_off} * gtgw_pkg::CELL_WIDTH);
		has_glyph = (char_code >= gtgw_pkg::GLYPH_BASE) && (char_code != gtgw_pkg::GLYPH_NONE);
		glyph_idx = char_code - gtgw_pkg::GLYPH_BASE;

		push_op.is_char    = req_type == gtgw_pkg::REQ_CHAR;
		push_op.lead_reset = cursor_q == {3'b000, gtgw_pkg::HALF_SPLIT};
		push_op.half       = cursor_q >= {3'b000, gtgw_pkg::HALF_SPLIT};
		push_op.page_cmd   = gtgw_pkg::PAGE_CMD + {5'b00000, text_page};
		push_op.col_cmd    = gtgw_pkg::COLUMN_CMD + col_mul
			+ (left ? gtgw_pkg::LEFT_OFFSET : 8'd0);
		push_op.col_half   = !left;
		push_op.glyph      = has_glyph ? gtgw_pkg::FONT_ROM[glyph_idx] : 40'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= 8'd0;
		end else if (push) begin
			if (req_type == gtgw_pkg::REQ_POSITION) begin
				cursor_q <= {3'b000, text_column};
			end else begin
				cursor_q <= cursor_q + 8'd1;
			end
		end
	end

endmodule

FILE: src/gtgw_queue.sv
module gtgw_queue #(
	parameter int DEPTH = gtgw_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gtgw_pkg::op_t    push_op,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output gtgw_pkg::op_t    head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	gtgw_pkg::op_t   slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = count_q == CW'(DEPTH);
	assign avail = count_q != '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

FILE: src/gtgw_back.sv
module gtgw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  gtgw_pkg::op_t    head,
	output logic             pop,
	output logic             wr_valid,
	input  logic             wr_ready,
	output logic             is_data,
	output logic [1:0]       panel,
	output logic [7:0]       bus_byte,
	output logic             last_of_run
);

	logic [2:0] step_q;
	logic       wr_valid_q;
	logic       is_data_q;
	logic [1:0] panel_q;
	logic [7:0] bus_byte_q;
	logic       last_q;

	logic       adv;
	logic [2:0] col;
	logic       n_data;
	logic [1:0] n_panel;
	logic [7:0] n_byte;
	logic       n_last;

	assign adv = avail && (!wr_valid_q || wr_ready);
	assign pop = adv && n_last;

	always_comb begin
		col     = step_q - {2'b00, head.lead_reset};
		n_data  = gtgw_pkg::WR_CMD;
		n_panel = gtgw_pkg::PANEL_BOTH;
		n_byte  = head.page_cmd;
		n_last  = 1'b0;
		if (!head.is_char) begin
			if (step_q != 3'd0) begin
				n_panel = {1'b0, head.col_half};
				n_byte  = head.col_cmd;
				n_last  = 1'b1;
			end
		end else if (head.lead_reset && step_q == 3'd0) begin
			n_panel = gtgw_pkg::PANEL_RIGHT;
			n_byte  = gtgw_pkg::COLUMN_CMD;
		end else begin
			n_data  = gtgw_pkg::WR_DATA;
			n_panel = {1'b0, head.half};
			n_last  = col == gtgw_pkg::GLYPH_COLS;
			case (col)
				3'd0:    n_byte = head.glyph[39:32];
				3'd1:    n_byte = head.glyph[31:24];
				3'd2:    n_byte = head.glyph[23:16];
				3'd3:    n_byte = head.glyph[15:8];
				3'd4:    n_byte = head.glyph[7:0];
				default: n_byte = gtgw_pkg::BLANK_BYTE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= 3'd0;
			wr_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				step_q     <= n_last ? 3'd0 : step_q + 3'd1;
				wr_valid_q <= 1'b1;
			end else if (wr_ready) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_data_q  <= n_data;
			panel_q    <= n_panel;
			bus_byte_q <= n_byte;
			last_q     <= n_last;
		end
	end

	assign wr_valid    = wr_valid_q;
	assign is_data     = is_data_q;
	assign panel       = panel_q;
	assign bus_byte    = bus_byte_q;
	assign last_of_run = last_q;

endmodule

FILE: src/glcd_text_glyph_writer.sv
// channel   handshake             payload
// request   req_valid/req_ready   req_type, text_page, text_column, char_code
// write     wr_valid/wr_ready     is_data, panel, bus_byte, last_of_run
//
// A position request gives 2 writes, a character request 6 or 7, one write per cycle while wr_ready stays high.
// The write sequencer sets the rate: it starts on a request only after the last write of the request ahead of it.
// Requests are taken while the queue has room, so the front runs ahead of the sequencer.
// Write output is registered; a low wr_ready holds it and stalls the sequencer only.
// arst_n clears the cursor, queue and sequencer.
module glcd_text_glyph_writer #(
	parameter int QUEUE_DEPTH = gtgw_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       req_type,
	input  logic [2:0] text_page,
	input  logic [4:0] text_column,
	input  logic [6:0] char_code,
	output logic       wr_valid,
	input  logic       wr_ready,
	output logic       is_data,
	output logic [1:0] panel,
	output logic [7:0] bus_byte,
	output logic       last_of_run
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_avail;
	gtgw_pkg::op_t push_op;
	gtgw_pkg::op_t head;

	gtgw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.text_page   (text_page),
		.text_column (text_column),
		.char_code   (char_code),
		.push        (push),
		.push_op     (push_op),
		.q_full      (q_full)
	);

	gtgw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.avail   (q_avail),
		.head    (head)
	);

	gtgw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (q_avail),
		.head        (head),
		.pop         (pop),
		.wr_valid    (wr_valid),
		.wr_ready    (wr_ready),
		.is_data     (is_data),
		.panel       (panel),
		.bus_byte    (bus_byte),
		.last_of_run (last_of_run)
	);

endmodule

FILE: src/gtgw_checker.sv
module gtgw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       wr_valid,
	input logic       wr_ready,
	input logic       is_data,
	input logic [1:0] panel,
	input logic [7:0] bus_byte,
	input logic       last_of_run
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !wr_ready |=> wr_valid && $stable(bus_byte) && $stable(panel)
			&& $stable(is_data) && $stable(last_of_run))
		else $error("write changed while stalled");

	a_panel: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> panel != 2'd3)
		else $error("bad panel code");

	a_data_half: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && is_data |-> panel != gtgw_pkg::PANEL_BOTH)
		else $error("data write to both halves");

	a_page_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && panel == gtgw_pkg::PANEL_BOTH |->
			!is_data && !last_of_run && bus_byte[7:3] == gtgw_pkg::PAGE_CMD[7:3])
		else $error("broadcast write is not a page command");

endmodule

bind glcd_text_glyph_writer gtgw_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.wr_valid    (wr_valid),
	.wr_ready    (wr_ready),
	.is_data     (is_data),
	.panel       (panel),
	.bus_byte    (bus_byte),
	.last_of_run (last_of_run)
);
